// File: hw/rtl/cplf_pkg.sv
// Shared types and constants for the chassis pitch leveling controller.
// Used by the serial multiplier and the top level; depends on nothing.
`default_nettype none

package cplf_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LIMIT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFT_GAIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_COEFF   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_ENTER_DEG = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_DEG     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RETILT_DEG     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS   = 3'd7;

    localparam logic [1:0] MODE_LEVEL   = 2'd0;
    localparam logic [1:0] MODE_TILTED  = 2'd1;
    localparam logic [1:0] MODE_SETTLED = 2'd2;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    localparam int PITCH_W     = 16;
    localparam int GAIN_W      = 8;
    localparam int COEFF_W     = 16;
    localparam int DEG_W       = 7;
    localparam int COUNT_W     = 16;
    localparam int MAG_W       = PITCH_W + 1;
    localparam int GAIN_PROD_W = PITCH_W + GAIN_W + 1;
    localparam int FILT_SHIFT  = 16;

    localparam int MUL_A_W   = PITCH_W + 1;
    localparam int MUL_B_W   = COEFF_W;
    localparam int MUL_P_W   = MUL_A_W + 1 + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    localparam logic signed [MUL_P_W-1:0] FILT_ROUND = 34'sd32768;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFE;
    localparam logic [COUNT_W-1:0] FLAT_TICKS = 16'd200;
    localparam int                 FLAT_DIFF  = 300;

    typedef struct packed {
        logic                       start;
        logic signed [MUL_A_W-1:0]  a;
        logic        [MUL_B_W-1:0]  b;
    } t_mul_req;

    typedef struct packed {
        logic                       done;
        logic signed [MUL_P_W-1:0]  product;
    } t_mul_rsp;

endpackage

`default_nettype wire

// File: hw/rtl/cplf_ser_mul.sv
// Bit-serial signed-by-unsigned multiplier, one multiplier bit per cycle.
// Depends on cplf_pkg for operand widths and the request and response types.
`default_nettype none

module cplf_ser_mul
    import cplf_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mul_req i_req,
    output t_mul_rsp      o_rsp
);

    logic signed [MUL_A_W:0]   r_hi, n_hi;
    logic        [MUL_B_W-1:0] r_lo, n_lo;
    logic signed [MUL_A_W-1:0] r_a, n_a;
    logic        [MUL_CNT_W-1:0] r_cnt, n_cnt;
    logic                      r_busy, n_busy;
    logic                      r_done, n_done;

    logic signed [MUL_A_W:0]   w_addend;
    logic signed [MUL_A_W:0]   w_sum;

    always_comb begin
        w_addend = r_lo[0] ? {r_a[MUL_A_W-1], r_a} : '0;
        w_sum    = r_hi + w_addend;
        n_hi     = r_hi;
        n_lo     = r_lo;
        n_a      = r_a;
        n_cnt    = r_cnt;
        n_busy   = r_busy;
        n_done   = 1'b0;
        if (i_req.start && !r_busy) begin
            n_hi   = '0;
            n_lo   = i_req.b;
            n_a    = i_req.a;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_hi  = w_sum >>> 1;
            n_lo  = {w_sum[0], r_lo[MUL_B_W-1:1]};
            n_cnt = r_cnt + MUL_CNT_W'(1);
            if (r_cnt == MUL_CNT_W'(MUL_B_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_hi <= n_hi;
        r_lo <= n_lo;
        r_a  <= n_a;
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.product = {r_hi, r_lo};

endmodule

`default_nettype wire

// File: hw/rtl/chassis_pitch_leveling_fsm.sv
// Chassis pitch leveling controller: pitch low-pass filter, posture state machine
// and four clamped lift targets. Depends on cplf_pkg and cplf_ser_mul.
//
// Usage: one input transaction per control tick carries the raw pitch, the
// normal-mode flag and the left-front and left-back lift feedback positions.
// Each input transaction yields exactly one output transaction with the four
// clamped lift targets and the posture mode.
// The time per tick is set by the shared bit-serial multiplier, which runs twice
// per tick: once for the filter weight and once for the lift gain.
// The input side stalls while a tick is being worked on. A finished result sits
// in the output register; the next input is accepted while it waits, and the
// block holds its following result until the receiver drops its stall.
// Configuration registers are written through the plain write port; the user must
// write them only while idle, as the block does not enforce it.
// Synchronous active-low reset restores the register defaults, level mode, zero
// filter state, zero counters and targets at the reset lower limit.
`default_nettype none

module chassis_pitch_leveling_fsm
    import cplf_pkg::*;
#(
    parameter int POSITION_BITS   = 24,
    parameter int PITCH_FRAC_BITS = 8
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]            i_cfg_index,
    input  wire logic [((POSITION_BITS > COEFF_W) ? POSITION_BITS : COEFF_W)-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic signed [PITCH_W-1:0]       i_pitch_raw,
    input  wire logic                            i_normal_mode,
    input  wire logic signed [POSITION_BITS-1:0] i_front_feedback,
    input  wire logic signed [POSITION_BITS-1:0] i_back_feedback,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic signed [POSITION_BITS-1:0]      o_left_front_target,
    output logic signed [POSITION_BITS-1:0]      o_right_front_target,
    output logic signed [POSITION_BITS-1:0]      o_left_back_target,
    output logic signed [POSITION_BITS-1:0]      o_right_back_target,
    output logic [1:0]                           o_posture_mode
);

    localparam int POS   = POSITION_BITS;
    localparam int FRAC  = PITCH_FRAC_BITS;
    localparam int NUM_W = ((POS + FRAC > 24) ? POS + FRAC : 24) + 2;
    localparam int MV_W  = NUM_W - FRAC;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_FILT   = 3'd1;
    localparam logic [2:0] ST_GAIN   = 3'd2;
    localparam logic [2:0] ST_LIFT   = 3'd3;
    localparam logic [2:0] ST_DECIDE = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    function automatic logic signed [POSITION_BITS-1:0] f_clamp(
        input logic signed [POSITION_BITS-1:0] t,
        input logic signed [POSITION_BITS-1:0] lo,
        input logic signed [POSITION_BITS-1:0] up
    );
        logic signed [POSITION_BITS-1:0] v;
        v = (t < lo) ? lo : t;
        v = (v > up) ? up : v;
        return v;
    endfunction

    logic [2:0]                r_state, n_state;

    logic signed [POS-1:0]     r_lower, n_lower;
    logic signed [POS-1:0]     r_upper, n_upper;
    logic [GAIN_W-1:0]         r_gain, n_gain;
    logic [COEFF_W-1:0]        r_coeff, n_coeff;
    logic [DEG_W-1:0]          r_tilt_deg, n_tilt_deg;
    logic [DEG_W-1:0]          r_settle_deg, n_settle_deg;
    logic [DEG_W-1:0]          r_retilt_deg, n_retilt_deg;
    logic [COUNT_W-1:0]        r_settle_ticks, n_settle_ticks;

    logic signed [PITCH_W-1:0] r_filt, n_filt;
    logic [1:0]                r_mode, n_mode;
    logic [COUNT_W-1:0]        r_calm_count, n_calm_count;
    logic [COUNT_W-1:0]        r_level_count, n_level_count;
    logic signed [POS-1:0]     r_lf, n_lf;
    logic signed [POS-1:0]     r_rf, n_rf;
    logic signed [POS-1:0]     r_lb, n_lb;
    logic signed [POS-1:0]     r_rb, n_rb;

    logic                      r_normal, n_normal;
    logic signed [POS-1:0]     r_ffb, n_ffb;
    logic signed [POS-1:0]     r_bfb, n_bfb;
    logic                      r_raise_back, n_raise_back;
    logic signed [MV_W-1:0]    r_move, n_move;

    logic                      r_out_valid, n_out_valid;
    logic signed [POS-1:0]     r_out_lf, n_out_lf;
    logic signed [POS-1:0]     r_out_rf, n_out_rf;
    logic signed [POS-1:0]     r_out_lb, n_out_lb;
    logic signed [POS-1:0]     r_out_rb, n_out_rb;
    logic [1:0]                r_out_mode, n_out_mode;

    t_mul_req                  w_mul_req;
    t_mul_rsp                  w_mul_rsp;

    logic                      w_in_accept;
    logic signed [MUL_P_W-1:0] w_filt_sum;
    logic signed [MUL_P_W-1:0] w_filt_shift;
    logic signed [PITCH_W+1:0] w_filt_new;
    logic [MAG_W-1:0]          w_abs;
    logic [MAG_W-1:0]          w_mag;
    logic                      w_raise;
    logic signed [POS-1:0]     w_fb;
    logic signed [NUM_W-1:0]   w_fb_ext;
    logic signed [NUM_W-1:0]   w_x;
    logic signed [NUM_W-1:0]   w_num;
    logic signed [NUM_W-1:0]   w_q;
    logic signed [NUM_W-1:0]   w_q_adj;
    logic signed [MV_W-1:0]    w_lo_ext;
    logic signed [MV_W-1:0]    w_up_ext;
    logic signed [MV_W-1:0]    w_mv_lo;
    logic signed [MV_W-1:0]    w_mv_cl;
    logic signed [POS:0]       w_diff;
    logic [POS:0]              w_diff_abs;
    logic [COUNT_W-1:0]        w_calm_next;
    logic [COUNT_W-1:0]        w_level_next;

    cplf_ser_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;

    always_comb begin
        w_mul_req.start = 1'b0;
        w_mul_req.a     = {r_filt[PITCH_W-1], r_filt};
        w_mul_req.b     = {{(MUL_B_W-GAIN_W){1'b0}}, r_gain};
        if (r_state == ST_IDLE) begin
            w_mul_req.start = w_in_accept;
            w_mul_req.a     = {i_pitch_raw[PITCH_W-1], i_pitch_raw}
                            - {r_filt[PITCH_W-1], r_filt};
            w_mul_req.b     = r_coeff;
        end else if (r_state == ST_GAIN) begin
            w_mul_req.start = 1'b1;
        end
    end

    always_comb begin
        w_filt_sum   = w_mul_rsp.product + FILT_ROUND;
        w_filt_shift = w_filt_sum >>> FILT_SHIFT;
        w_filt_new   = {{2{r_filt[PITCH_W-1]}}, r_filt} + w_filt_shift[PITCH_W+1:0];

        w_abs = r_filt[PITCH_W-1] ? -{r_filt[PITCH_W-1], r_filt} : {1'b0, r_filt};
        w_mag = w_abs >> FRAC;

        w_raise  = (r_filt > 0) ? (r_lf <= r_lower) : !(r_lb <= r_lower);
        w_fb     = w_raise ? r_bfb : r_ffb;
        w_fb_ext = {{(NUM_W-POS-FRAC){w_fb[POS-1]}}, w_fb, {FRAC{1'b0}}};
        w_x      = {{(NUM_W-GAIN_PROD_W){w_mul_rsp.product[GAIN_PROD_W-1]}},
                    w_mul_rsp.product[GAIN_PROD_W-1:0]};
        w_num    = w_fb_ext + (w_raise ? w_x : -w_x);
        w_q      = w_num >>> FRAC;
        w_q_adj  = (w_num[NUM_W-1] && (|w_num[FRAC-1:0])) ? w_q + NUM_W'(1) : w_q;

        w_lo_ext = {{(MV_W-POS){r_lower[POS-1]}}, r_lower};
        w_up_ext = {{(MV_W-POS){r_upper[POS-1]}}, r_upper};
        w_mv_lo  = (r_move < w_lo_ext) ? w_lo_ext : r_move;
        w_mv_cl  = (w_mv_lo > w_up_ext) ? w_up_ext : w_mv_lo;

        w_diff     = {r_lf[POS-1], r_lf} - {r_lb[POS-1], r_lb};
        w_diff_abs = w_diff[POS] ? -w_diff : w_diff;

        w_calm_next  = ((w_mag < {{(MAG_W-DEG_W){1'b0}}, r_settle_deg})
                        && (r_calm_count < COUNT_MAX))
                       ? r_calm_count + COUNT_W'(1) : '0;
        w_level_next = r_level_count;
        if ((w_diff_abs < (POS+1)'(FLAT_DIFF)) && (r_level_count < COUNT_MAX)) begin
            w_level_next = r_level_count + COUNT_W'(1);
        end
    end

    always_comb begin
        n_state        = r_state;
        n_lower        = r_lower;
        n_upper        = r_upper;
        n_gain         = r_gain;
        n_coeff        = r_coeff;
        n_tilt_deg     = r_tilt_deg;
        n_settle_deg   = r_settle_deg;
        n_retilt_deg   = r_retilt_deg;
        n_settle_ticks = r_settle_ticks;
        n_filt         = r_filt;
        n_mode         = r_mode;
        n_calm_count   = r_calm_count;
        n_level_count  = r_level_count;
        n_lf           = r_lf;
        n_rf           = r_rf;
        n_lb           = r_lb;
        n_rb           = r_rb;
        n_normal       = r_normal;
        n_ffb          = r_ffb;
        n_bfb          = r_bfb;
        n_raise_back   = r_raise_back;
        n_move         = r_move;
        n_out_valid    = r_out_valid && i_out_stall;
        n_out_lf       = r_out_lf;
        n_out_rf       = r_out_rf;
        n_out_lb       = r_out_lb;
        n_out_rb       = r_out_rb;
        n_out_mode     = r_out_mode;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LOWER_LIMIT:    n_lower        = i_cfg_data[POS-1:0];
                CFG_UPPER_LIMIT:    n_upper        = i_cfg_data[POS-1:0];
                CFG_LIFT_GAIN:      n_gain         = i_cfg_data[GAIN_W-1:0];
                CFG_FILTER_COEFF:   n_coeff        = i_cfg_data[COEFF_W-1:0];
                CFG_TILT_ENTER_DEG: n_tilt_deg     = i_cfg_data[DEG_W-1:0];
                CFG_SETTLE_DEG:     n_settle_deg   = i_cfg_data[DEG_W-1:0];
                CFG_RETILT_DEG:     n_retilt_deg   = i_cfg_data[DEG_W-1:0];
                CFG_SETTLE_TICKS:   n_settle_ticks = i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    n_normal = i_normal_mode;
                    n_ffb    = i_front_feedback;
                    n_bfb    = i_back_feedback;
                    n_state  = ST_FILT;
                end
            end
            ST_FILT: begin
                if (w_mul_rsp.done) begin
                    n_filt  = w_filt_new[PITCH_W-1:0];
                    n_state = ST_GAIN;
                end
            end
            ST_GAIN: begin
                n_state = ST_LIFT;
            end
            ST_LIFT: begin
                if (w_mul_rsp.done) begin
                    n_raise_back = w_raise;
                    n_move       = w_q_adj[MV_W-1:0];
                    n_state      = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (r_normal) begin
                    unique case (r_mode)
                        MODE_LEVEL: begin
                            n_lf = r_lower;
                            n_rf = r_lower;
                            n_lb = r_lower;
                            n_rb = r_lower;
                            if (w_mag > {{(MAG_W-DEG_W){1'b0}}, r_tilt_deg}) begin
                                n_mode = MODE_TILTED;
                            end
                        end
                        MODE_TILTED: begin
                            if (r_raise_back) begin
                                n_lb = w_mv_cl[POS-1:0];
                                n_rb = w_mv_cl[POS-1:0];
                            end else begin
                                n_lf = w_mv_cl[POS-1:0];
                                n_rf = w_mv_cl[POS-1:0];
                            end
                            if (w_calm_next > r_settle_ticks) begin
                                n_mode       = MODE_SETTLED;
                                n_calm_count = '0;
                            end else begin
                                n_calm_count = w_calm_next;
                            end
                        end
                        MODE_SETTLED: begin
                            if (w_mag > {{(MAG_W-DEG_W){1'b0}}, r_retilt_deg}) begin
                                n_mode = MODE_TILTED;
                                if (r_level_count > FLAT_TICKS) begin
                                    n_mode        = MODE_LEVEL;
                                    n_level_count = '0;
                                end
                            end else if (w_level_next > FLAT_TICKS) begin
                                n_mode        = MODE_LEVEL;
                                n_level_count = '0;
                            end else begin
                                n_level_count = w_level_next;
                            end
                        end
                        default: ;
                    endcase
                end
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_lf        = f_clamp(r_lf, r_lower, r_upper);
                    n_rf        = f_clamp(r_rf, r_lower, r_upper);
                    n_lb        = f_clamp(r_lb, r_lower, r_upper);
                    n_rb        = f_clamp(r_rb, r_lower, r_upper);
                    n_out_lf    = n_lf;
                    n_out_rf    = n_rf;
                    n_out_lb    = n_lb;
                    n_out_rb    = n_rb;
                    n_out_mode  = r_mode;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_lower        <= '0;
            r_upper        <= {1'b0, {(POS-1){1'b1}}};
            r_gain         <= 8'd10;
            r_coeff        <= 16'd3277;
            r_tilt_deg     <= 7'd8;
            r_settle_deg   <= 7'd2;
            r_retilt_deg   <= 7'd4;
            r_settle_ticks <= 16'd500;
            r_filt         <= '0;
            r_mode         <= MODE_LEVEL;
            r_calm_count   <= '0;
            r_level_count  <= '0;
            r_lf           <= '0;
            r_rf           <= '0;
            r_lb           <= '0;
            r_rb           <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_lower        <= n_lower;
            r_upper        <= n_upper;
            r_gain         <= n_gain;
            r_coeff        <= n_coeff;
            r_tilt_deg     <= n_tilt_deg;
            r_settle_deg   <= n_settle_deg;
            r_retilt_deg   <= n_retilt_deg;
            r_settle_ticks <= n_settle_ticks;
            r_filt         <= n_filt;
            r_mode         <= n_mode;
            r_calm_count   <= n_calm_count;
            r_level_count  <= n_level_count;
            r_lf           <= n_lf;
            r_rf           <= n_rf;
            r_lb           <= n_lb;
            r_rb           <= n_rb;
            r_out_valid    <= n_out_valid;
        end
        r_normal     <= n_normal;
        r_ffb        <= n_ffb;
        r_bfb        <= n_bfb;
        r_raise_back <= n_raise_back;
        r_move       <= n_move;
        r_out_lf     <= n_out_lf;
        r_out_rf     <= n_out_rf;
        r_out_lb     <= n_out_lb;
        r_out_rb     <= n_out_rb;
        r_out_mode   <= n_out_mode;
    end

    assign o_out_valid          = r_out_valid;
    assign o_left_front_target  = r_out_lf;
    assign o_right_front_target = r_out_rf;
    assign o_left_back_target   = r_out_lb;
    assign o_right_back_target  = r_out_rb;
    assign o_posture_mode       = r_out_mode;

`ifndef SYNTHESIS
    a_pairs_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lf == r_rf) && (r_lb == r_rb))
        else $error("Left and right lift targets diverged within a pair.");

    a_mode_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_posture_mode != MODE_UNUSED))
        else $error("Output transaction carries an unused posture mode.");

    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_rsp.done |-> ((r_state == ST_FILT) || (r_state == ST_LIFT)))
        else $error("Multiplier finished outside a state that waits for it.");
`endif

endmodule

`default_nettype wire
